### hw/rtl/banded_min_path_cost_accumulator_macros.svh
// Assertion macros shared by the banded minimum-path cost accumulator RTL.
`ifndef BANDED_MIN_PATH_COST_ACCUMULATOR_MACROS_SVH
`define BANDED_MIN_PATH_COST_ACCUMULATOR_MACROS_SVH

`ifndef ASSERT_OFF
// Checks that a implies b in the same cycle.
`define BMPCA_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed");
// Checks that a implies b in the following cycle.
`define BMPCA_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define BMPCA_ASSERT_SAME(label, clk, rst_n, a, b)
`define BMPCA_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

### hw/rtl/bmpca_pkg.sv
// Package with widths, register codes and reset values of the path cost accumulator.
package bmpca_pkg;

    localparam int LOCAL_COST_W = 24;
    localparam int ROW_W        = 10;
    localparam int COST_W       = 40;
    localparam int MOVE_W       = 4;
    localparam int NO_PATH_W    = 38;

    localparam int IN_TDATA_W   = 56;
    localparam int OUT_TDATA_W  = 48;

    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 38;

    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_LIMIT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_PATH_COST = 1'b1;

    localparam logic [MOVE_W-1:0]    MOVE_LIMIT_RST   = 4'd3;
    localparam logic [NO_PATH_W-1:0] NO_PATH_COST_RST = {NO_PATH_W{1'b1}};

    localparam int COLUMN_HEIGHT_DEF = 1024;
    localparam int MAX_MOVE_DEF      = 15;

endpackage

### hw/rtl/bmpca_cost_ram.sv
// Two-bank column cost memory with one write port and one registered read port.
module bmpca_cost_ram
    import bmpca_pkg::*;
#(
    parameter int ADDR_W = 11
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [COST_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [COST_W-1:0] o_rdata
);

    logic [COST_W-1:0] r_mem [0:(1 << ADDR_W)-1];
    logic [COST_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/bmpca_ctrl.sv
// Item sequencer: window setup, previous-column scan, saturating add and write-back.
`include "banded_min_path_cost_accumulator_macros.svh"

module bmpca_ctrl
    import bmpca_pkg::*;
#(
    parameter int COLUMN_HEIGHT = COLUMN_HEIGHT_DEF,
    parameter int MAX_MOVE      = MAX_MOVE_DEF,
    parameter int HT_W          = $clog2(COLUMN_HEIGHT),
    parameter int ADDR_W        = HT_W + 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   o_mem_we,
    output logic [ADDR_W-1:0]      o_mem_waddr,
    output logic [COST_W-1:0]      o_mem_wdata,
    output logic                   o_mem_re,
    output logic [ADDR_W-1:0]      o_mem_raddr,
    input  logic [COST_W-1:0]      i_mem_rdata
);

    localparam int WIN_W = ((ROW_W > HT_W) ? ROW_W : HT_W) + 2;
    localparam int SUM_W = COST_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    t_state r_state;

    logic [MOVE_W-1:0]       r_move_limit;
    logic [NO_PATH_W-1:0]    r_no_path_cost;

    logic                    r_bank;
    logic [ROW_W-1:0]        r_prev_top;
    logic [ROW_W-1:0]        r_prev_bottom;
    logic [ROW_W-1:0]        r_cur_top;
    logic [ROW_W-1:0]        r_cur_bottom;

    logic signed [LOCAL_COST_W-1:0] r_local;
    logic [ROW_W-1:0]        r_row;
    logic                    r_in_band;
    logic                    r_search;
    logic [HT_W-1:0]         r_k;
    logic [HT_W-1:0]         r_hi;
    logic                    r_issue_done;
    logic                    r_rd_vld;
    logic                    r_found;
    logic signed [COST_W-1:0] r_best;

    logic                    r_out_valid;
    logic signed [COST_W-1:0] r_out_cost;
    logic                    r_out_in_band;
    logic                    r_out_nopred;

    // Unpacked input item.
    logic signed [LOCAL_COST_W-1:0] w_local;
    logic [ROW_W-1:0]        w_row;
    logic [ROW_W-1:0]        w_top;
    logic [ROW_W-1:0]        w_bottom;
    logic                    w_first;

    logic                    w_accept;
    logic [ROW_W-1:0]        n_prev_top;
    logic [ROW_W-1:0]        n_prev_bottom;
    logic                    n_bank;
    logic                    w_in_band;

    logic [WIN_W-1:0]        w_move_ext;
    logic signed [WIN_W-1:0] w_d;
    logic signed [WIN_W-1:0] w_lo0;
    logic signed [WIN_W-1:0] w_hi0;
    logic signed [WIN_W-1:0] w_lo1;
    logic signed [WIN_W-1:0] w_hi1;
    logic signed [WIN_W-1:0] w_lo;
    logic signed [WIN_W-1:0] w_hi;
    logic signed [WIN_W-1:0] w_pt;
    logic signed [WIN_W-1:0] w_pb;

    logic signed [SUM_W-1:0]  w_addend;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [COST_W-1:0] w_sat;
    logic                     w_nopred;
    logic                     w_out_free;
    logic                     w_finish;
    logic                     w_issue;

    assign w_local  = s_axis_tdata[LOCAL_COST_W-1:0];
    assign w_row    = s_axis_tdata[LOCAL_COST_W +: ROW_W];
    assign w_top    = s_axis_tdata[LOCAL_COST_W + ROW_W +: ROW_W];
    assign w_bottom = s_axis_tdata[LOCAL_COST_W + 2*ROW_W +: ROW_W];
    assign w_first  = s_axis_tdata[LOCAL_COST_W + 3*ROW_W];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Row zero opens a new column: banks swap and the finished band becomes the previous band.
    assign n_bank        = (w_row == '0) ? ~r_bank : r_bank;
    assign n_prev_top    = (w_row == '0) ? r_cur_top : r_prev_top;
    assign n_prev_bottom = (w_row == '0) ? r_cur_bottom : r_prev_bottom;
    assign w_in_band     = (w_row >= w_top) && (w_row <= w_bottom);

    // Window of the previous column, clipped to its band and to the store.
    assign w_move_ext = WIN_W'(r_move_limit);
    assign w_d   = (w_move_ext > WIN_W'(MAX_MOVE)) ? WIN_W'(MAX_MOVE) : w_move_ext;
    assign w_pt  = WIN_W'(n_prev_top);
    assign w_pb  = WIN_W'(n_prev_bottom);
    assign w_lo0 = WIN_W'(w_row) - w_d;
    assign w_hi0 = WIN_W'(w_row) + w_d;
    assign w_lo1 = (w_lo0 < w_pt) ? w_pt : w_lo0;
    assign w_hi1 = (w_hi0 > w_pb) ? w_pb : w_hi0;
    assign w_lo  = (w_lo1 < 0) ? '0 : w_lo1;
    assign w_hi  = (w_hi1 > WIN_W'(COLUMN_HEIGHT - 1)) ? WIN_W'(COLUMN_HEIGHT - 1) : w_hi1;

    assign w_issue = (r_state == ST_SCAN) && !r_issue_done;

    // Saturating add of the chosen predecessor cost.
    always_comb begin
        w_nopred = 1'b0;
        if (!r_search) begin
            w_addend = '0;
        end else if (r_found) begin
            w_addend = SUM_W'(r_best);
        end else begin
            w_addend = SUM_W'({1'b0, r_no_path_cost});
            w_nopred = 1'b1;
        end
        w_sum = SUM_W'(r_local) + w_addend;
        if (w_sum[SUM_W-1] != w_sum[SUM_W-2]) begin
            w_sat = w_sum[SUM_W-1] ? {1'b1, {(COST_W-1){1'b0}}} : {1'b0, {(COST_W-1){1'b1}}};
        end else begin
            w_sat = w_sum[COST_W-1:0];
        end
    end

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_finish   = (r_state == ST_FINISH) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_move_limit   <= MOVE_LIMIT_RST;
            r_no_path_cost <= NO_PATH_COST_RST;
            r_bank         <= 1'b0;
            r_prev_top     <= '0;
            r_prev_bottom  <= '0;
            r_cur_top      <= '0;
            r_cur_bottom   <= '0;
            r_issue_done   <= 1'b0;
            r_rd_vld       <= 1'b0;
            r_found        <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MOVE_LIMIT:   r_move_limit   <= i_cfg_data[MOVE_W-1:0];
                    CFG_NO_PATH_COST: r_no_path_cost <= i_cfg_data[NO_PATH_W-1:0];
                    default: ;
                endcase
            end

            if (m_axis_tready && !w_finish) begin
                r_out_valid <= 1'b0;
            end

            r_rd_vld <= w_issue;

            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_bank        <= n_bank;
                        r_prev_top    <= n_prev_top;
                        r_prev_bottom <= n_prev_bottom;
                        r_cur_top     <= w_top;
                        r_cur_bottom  <= w_bottom;
                        r_local       <= w_local;
                        r_row         <= w_row;
                        r_in_band     <= w_in_band;
                        r_search      <= w_in_band && !w_first;
                        r_k           <= w_lo[HT_W-1:0];
                        r_hi          <= w_hi[HT_W-1:0];
                        r_issue_done  <= 1'b0;
                        r_found       <= 1'b0;
                        if (w_in_band && !w_first && (w_lo <= w_hi)) begin
                            r_state <= ST_SCAN;
                        end else begin
                            r_state <= ST_FINISH;
                        end
                    end
                end
                ST_SCAN: begin
                    if (!r_issue_done) begin
                        if (r_k == r_hi) begin
                            r_issue_done <= 1'b1;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                    if (r_rd_vld) begin
                        if (!r_found || ($signed(i_mem_rdata) < r_best)) begin
                            r_best <= $signed(i_mem_rdata);
                        end
                        r_found <= 1'b1;
                    end
                    // The last read has been compared once no read is in flight.
                    if (r_issue_done && !r_rd_vld) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (w_out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_cost    <= w_sat;
                        r_out_in_band <= r_in_band;
                        r_out_nopred  <= w_nopred;
                        r_state       <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_mem_re    = w_issue;
    assign o_mem_raddr = {~r_bank, r_k};
    assign o_mem_we    = w_finish && (WIN_W'(r_row) < WIN_W'(COLUMN_HEIGHT));
    assign o_mem_waddr = {r_bank, HT_W'(r_row)};
    assign o_mem_wdata = w_sat;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - COST_W - 2){1'b0}},
                            r_out_nopred, r_out_in_band, r_out_cost};

    `BMPCA_ASSERT_SAME(a_no_rw_overlap, i_clk, i_rst_n, o_mem_we, !o_mem_re)
    `BMPCA_ASSERT_SAME(a_read_other_bank, i_clk, i_rst_n, o_mem_re, o_mem_raddr[ADDR_W-1] != r_bank)
    `BMPCA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, r_state != ST_IDLE)
    `BMPCA_ASSERT_SAME(a_nopred_in_band, i_clk, i_rst_n, r_out_valid, !r_out_nopred || r_out_in_band)

endmodule

### hw/rtl/banded_min_path_cost_accumulator.sv
// Top level of the banded minimum-path cost accumulator: sequencer and cost memory.
// An accepted pass-through item or empty window goes straight to the finish state, which registers
// the result; a window of n previous-column rows is first scanned, one memory read a cycle.
// The next item is accepted only once the block is back in idle after the result is registered, so
// it takes no new item before it is through with the last; a result waiting on the sink stalls the input.
// Reset (synchronous, active low) resets control state and configuration; data and memory are not cleared.
module banded_min_path_cost_accumulator
    import bmpca_pkg::*;
#(
    parameter int COLUMN_HEIGHT = COLUMN_HEIGHT_DEF,
    parameter int MAX_MOVE      = MAX_MOVE_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // local_cost[23:0], row[33:24], band_top[43:34], band_bottom[53:44], first_column[54]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // path_cost[39:0], in_band[40], no_predecessor[41]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int HT_W   = $clog2(COLUMN_HEIGHT);
    localparam int ADDR_W = HT_W + 1;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [COST_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [COST_W-1:0] mem_rdata;

    bmpca_ctrl #(
        .COLUMN_HEIGHT (COLUMN_HEIGHT),
        .MAX_MOVE      (MAX_MOVE),
        .HT_W          (HT_W),
        .ADDR_W        (ADDR_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_mem_re      (mem_re),
        .o_mem_raddr   (mem_raddr),
        .i_mem_rdata   (mem_rdata)
    );

    bmpca_cost_ram #(
        .ADDR_W (ADDR_W)
    ) u_cost_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

### tb/sv/banded_min_path_cost_accumulator_tb.sv
// Self-checking testbench for the banded minimum-path cost accumulator.
module banded_min_path_cost_accumulator_tb;
    import bmpca_pkg::*;

    // Input item as it sits in s_axis_tdata, lowest field last.
    typedef struct packed {
        logic              first_column;
        logic [ROW_W-1:0]  band_bottom;
        logic [ROW_W-1:0]  band_top;
        logic [ROW_W-1:0]  row;
        logic [LOCAL_COST_W-1:0] local_cost;
    } t_pixel;

    typedef struct packed {
        logic              no_predecessor;
        logic              in_band;
        logic [COST_W-1:0] path_cost;
    } t_path_res;

    localparam longint COST_HI = (longint'(1) <<< (COST_W - 1)) - 1;
    localparam longint COST_LO = -COST_HI - 1;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx     = CFG_MOVE_LIMIT;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // local_cost[23:0], row[33:24], band_top[43:34], band_bottom[53:44], first_column[54]
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b1;
    // path_cost[39:0], in_band[40], no_predecessor[41]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    banded_min_path_cost_accumulator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Predictor state: two cost banks, the bands of the current and previous column.
    logic [COST_W-1:0]    cost_mem     [2][COLUMN_HEIGHT_DEF];
    bit                   cost_written [2][COLUMN_HEIGHT_DEF];
    logic [ROW_W-1:0]     prev_top = '0;
    logic [ROW_W-1:0]     prev_bot = '0;
    logic [ROW_W-1:0]     cur_top  = '0;
    logic [ROW_W-1:0]     cur_bot  = '0;
    bit                   bank_sel = 1'b0;
    logic [MOVE_W-1:0]    cfg_move    = MOVE_LIMIT_RST;
    logic [NO_PATH_W-1:0] cfg_no_path = NO_PATH_COST_RST;

    t_path_res expected_paths[$];
    int        mismatches     = 0;
    int        pixels_sent    = 0;
    bit        tx_idle_on     = 1'b0;
    bit        rx_idle_on     = 1'b0;
    int        rx_hold_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Previous-column rows searched for a pixel, as seen after its own column-start update.
    function automatic void scan_window(input t_pixel p, output int lo, output int hi,
                                       output bit rd_bank);
        int span;
        int ptop;
        int pbot;
        span = (cfg_move > MAX_MOVE_DEF) ? MAX_MOVE_DEF : int'(cfg_move);
        if (p.row == '0) begin
            ptop    = int'(cur_top);
            pbot    = int'(cur_bot);
            rd_bank = bank_sel;
        end else begin
            ptop    = int'(prev_top);
            pbot    = int'(prev_bot);
            rd_bank = ~bank_sel;
        end
        lo = int'(p.row) - span;
        hi = int'(p.row) + span;
        if (lo < ptop) lo = ptop;
        if (hi > pbot) hi = pbot;
        if (lo < 0) lo = 0;
        if (hi > COLUMN_HEIGHT_DEF - 1) hi = COLUMN_HEIGHT_DEF - 1;
    endfunction

    // True when the pixel would search a cost entry that was never written.
    function automatic bit reads_blank(input t_pixel p);
        int lo;
        int hi;
        bit rb;
        if (p.first_column || p.row < p.band_top || p.row > p.band_bottom) return 1'b0;
        scan_window(p, lo, hi, rb);
        for (int k = lo; k <= hi; k++)
            if (!cost_written[rb][k[ROW_W-1:0]]) return 1'b1;
        return 1'b0;
    endfunction

    function automatic t_path_res predict_path(input t_pixel p);
        t_path_res r;
        int        lo;
        int        hi;
        bit        rb;
        bit        found;
        longint    best;
        longint    v;
        longint    total;
        scan_window(p, lo, hi, rb);
        if (p.row == '0) begin
            bank_sel = ~bank_sel;
            prev_top = cur_top;
            prev_bot = cur_bot;
        end
        cur_top = p.band_top;
        cur_bot = p.band_bottom;
        r.in_band        = (p.row >= p.band_top) && (p.row <= p.band_bottom);
        r.no_predecessor = 1'b0;
        total            = longint'($signed(p.local_cost));
        if (r.in_band && !p.first_column) begin
            found = 1'b0;
            best  = 0;
            for (int k = lo; k <= hi; k++) begin
                v = longint'($signed(cost_mem[rb][k[ROW_W-1:0]]));
                if (!found || v < best) begin
                    best  = v;
                    found = 1'b1;
                end
            end
            if (found) begin
                total += best;
            end else begin
                total += longint'(cfg_no_path);
                r.no_predecessor = 1'b1;
            end
            if (total > COST_HI) total = COST_HI;
            else if (total < COST_LO) total = COST_LO;
        end
        r.path_cost = total[COST_W-1:0];
        // Every 10-bit row fits the store, so every result is kept.
        cost_mem[bank_sel][p.row]     = r.path_cost;
        cost_written[bank_sel][p.row] = 1'b1;
        return r;
    endfunction

    function automatic t_pixel px(input int cost, input int row, input int top, input int bot,
                                  input bit first_col);
        t_pixel p;
        p.local_cost   = cost[LOCAL_COST_W-1:0];
        p.row          = row[ROW_W-1:0];
        p.band_top     = top[ROW_W-1:0];
        p.band_bottom  = bot[ROW_W-1:0];
        p.first_column = first_col;
        return p;
    endfunction

    function automatic int rand_cost();
        case ($urandom_range(0, 7))
            0: return 8388607;
            1: return -8388608;
            2: return int'($urandom_range(0, 4000)) - 2000;
            default: return int'($urandom());
        endcase
    endfunction

    task automatic send_pixel(input t_pixel p);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        // Searching rows never written is not a legal use, so such a pixel is made a
        // first-column pixel instead.
        if (reads_blank(p)) p.first_column = 1'b1;
        expected_paths.push_back(predict_path(p));
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, p};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pixels_sent++;
    endtask

    task automatic pause_for_results();
        s_axis_tvalid <= 1'b0;
        while (expected_paths.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == CFG_MOVE_LIMIT) cfg_move = data[MOVE_W-1:0];
        else cfg_no_path = data[NO_PATH_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_random_column();
        int h;
        int top;
        int bot;
        int r;
        bit first_col;
        first_col = ($urandom_range(0, 11) == 0);
        case ($urandom_range(0, 19))
            14, 15, 16: begin
                // Rows near the bottom edge of the store.
                top = $urandom_range(990, 1023);
                bot = $urandom_range(top, 1023);
                send_pixel(px(rand_cost(), 0, top, bot, first_col));
                for (r = $urandom_range(1000, 1016); r <= 1023; r++)
                    send_pixel(px(rand_cost(), r, top, bot, first_col));
            end
            17: begin
                top = $urandom_range(0, 1023);
                bot = $urandom_range(0, 1023);
                r   = 0;
                while (r <= 1023) begin
                    send_pixel(px(rand_cost(), r, top, bot, first_col));
                    r += $urandom_range(1, 200);
                end
            end
            18, 19: begin
                // Broken sequences: rows out of order, band changing on every item.
                repeat (8) begin
                    r = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 1023);
                    send_pixel(px(rand_cost(), r, $urandom_range(0, 1023),
                                  $urandom_range(0, 1023), ($urandom_range(0, 1) != 0)));
                end
            end
            default: begin
                h = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 64) : $urandom_range(3, 24);
                if ($urandom_range(0, 9) == 0) begin
                    top = $urandom_range(1, h);
                    bot = $urandom_range(0, top - 1);
                end else begin
                    top = $urandom_range(0, h / 2);
                    bot = $urandom_range(top, h - 1);
                end
                for (r = 0; r < h; r++)
                    send_pixel(px(rand_cost(), r, top, bot, first_col));
            end
        endcase
    endtask

    task automatic test_first_column();
        send_pixel(px(8388607, 0, 1, 4, 1'b1));
        send_pixel(px(-8388608, 1, 1, 4, 1'b1));
        send_pixel(px(0, 2, 1, 4, 1'b1));
        send_pixel(px(1000, 3, 1, 4, 1'b1));
        send_pixel(px(-5, 4, 1, 4, 1'b1));
    endtask

    task automatic test_window_min();
        send_pixel(px(-8388608, 0, 0, 4, 1'b0));
        send_pixel(px(8388607, 1, 0, 4, 1'b0));
        send_pixel(px(12, 2, 0, 4, 1'b0));
        send_pixel(px(-3000, 3, 0, 4, 1'b0));
        send_pixel(px(0, 4, 0, 4, 1'b0));
    endtask

    // An inverted band passes costs through and leaves the next column with no window.
    task automatic test_empty_band();
        for (int r = 0; r < 3; r++) send_pixel(px(100 * r - 7, r, 6, 2, 1'b0));
        for (int r = 0; r < 3; r++) send_pixel(px(-8388608 + r, r, 0, 2, 1'b0));
    endtask

    task automatic test_config_extremes();
        pause_for_results();
        cfg_write(CFG_MOVE_LIMIT, '0);
        cfg_write(CFG_NO_PATH_COST, '0);
        for (int r = 0; r < 6; r++) send_pixel(px(rand_cost(), r, 0, 9, 1'b0));
    endtask

    task automatic test_random_columns(input int target);
        int                   phase_start;
        logic [MOVE_W-1:0]    mv;
        logic [NO_PATH_W-1:0] np;
        while (pixels_sent < target) begin
            pause_for_results();
            case ($urandom_range(0, 3))
                0: mv = '0;
                1: mv = 4'd15;
                default: mv = MOVE_W'($urandom_range(0, 15));
            endcase
            case ($urandom_range(0, 3))
                0: np = '0;
                1: np = NO_PATH_COST_RST;
                2: np = NO_PATH_W'($urandom_range(0, 4096));
                default: begin
                    np[31:0]  = $urandom();
                    np[37:32] = 6'($urandom_range(0, 63));
                end
            endcase
            cfg_write(CFG_MOVE_LIMIT, CFG_DATA_W'(mv));
            cfg_write(CFG_NO_PATH_COST, np);
            tx_idle_on  = ($urandom_range(0, 3) != 0);
            rx_idle_on  = ($urandom_range(0, 3) != 0);
            phase_start = pixels_sent;
            while (pixels_sent - phase_start < 120 && pixels_sent < target)
                send_random_column();
        end
    endtask

    // The sink holds off while a full column is offered, so the block backs up.
    task automatic test_backpressure();
        pause_for_results();
        tx_idle_on     = 1'b0;
        rx_hold_cycles = 300;
        @(posedge i_clk);
        for (int r = 0; r < 20; r++) send_pixel(px(rand_cost(), r, 0, 19, 1'b0));
        pause_for_results();
    endtask

    task automatic test_steady_tail(input int target);
        pause_for_results();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        while (pixels_sent < target) send_random_column();
        pause_for_results();
    endtask

    initial begin : result_sink
        forever begin
            @(posedge i_clk);
            if (rx_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_cycles = 0;
                m_axis_tready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_paths
        t_path_res got;
        t_path_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[$bits(t_path_res)-1:0];
            if (expected_paths.size() == 0) begin
                $error("unexpected item: path_cost %0d", $signed(got.path_cost));
                mismatches++;
            end else begin
                want = expected_paths.pop_front();
                if (got.path_cost !== want.path_cost) begin
                    $error("path_cost: expected %0d, actual %0d",
                           $signed(want.path_cost), $signed(got.path_cost));
                    mismatches++;
                end
                if (got.in_band !== want.in_band) begin
                    $error("in_band: expected %0b, actual %0b", want.in_band, got.in_band);
                    mismatches++;
                end
                if (got.no_predecessor !== want.no_predecessor) begin
                    $error("no_predecessor: expected %0b, actual %0b",
                           want.no_predecessor, got.no_predecessor);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_first_column();
        test_window_min();
        test_empty_band();
        test_config_extremes();
        test_random_columns(600);
        test_backpressure();
        test_random_columns(1150);
        test_steady_tail(1300);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
